@@ rtl/dfs_discovery_finish_times_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the DFS block checker
// ---------------------------------------------------------------------------
`ifndef DFS_DISCOVERY_FINISH_TIMES_ASSERT_SVH
`define DFS_DISCOVERY_FINISH_TIMES_ASSERT_SVH

// same-cycle implication
`define DFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfs assertion failed");

// next-cycle implication
`define DFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfs assertion failed");

`endif

@@ rtl/dfs_pkg.sv @@
// ---------------------------------------------------------------------------
// dfs_pkg
// Shared constants and codes of the CSR depth-first search block.
// ---------------------------------------------------------------------------
package dfs_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int STACK_DEPTH  = 8192;

    localparam int VW  = $clog2(MAX_VERTICES);      // vertex id bits
    localparam int CW  = VW + 1;                    // counts and stamps
    localparam int OW  = 13;                        // row offset bits
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int SAW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        OP_LOAD_ROW  = 2'd0,
        OP_LOAD_EDGE = 2'd1,
        OP_RUN       = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SRC = 2'd1,
        ST_BAD_RANK = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MARK_NEW  = 2'd0,
        MARK_OPEN = 2'd1,
        MARK_DONE = 2'd2
    } t_mark;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_FULL_SWEEP   = 1'b1;
endpackage

@@ rtl/dfs_ram.sv @@
// ---------------------------------------------------------------------------
// dfs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module dfs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/dfs_discovery_finish_times.sv @@
// ---------------------------------------------------------------------------
// dfs_discovery_finish_times
// Iterative stack DFS over a CSR graph with discovery/finish stamps.
// ---------------------------------------------------------------------------
// channel   | handshake                 | payload
// request   | i_in_valid / o_in_ready   | operation, slot, load_value, source_vertex
// result    | o_out_valid / i_out_ready | status, visited_total, record fields
// config    | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A load answers from S_IDLE; a read passes S_RD1, S_RD2. A run first clears all
// mark and parent entries. A stack pop then passes S_POP, S_ENT, a newly discovered
// vertex S_CHK, S_ROW0, S_ROW1, S_EDGE (mark check, two row offset reads, end of
// scan), each edge S_EDGE, S_NB, S_NBCHK; full sweep root probes S_ROOT, S_ROOTCHK.
// Synchronous active-low reset clears control only; RAMs hold no reset.
// A waiting result holds off the next request; a finished run or read waits
// in its last state until the result register is free.
module dfs_discovery_finish_times (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_operation,
    input  logic [12:0]                i_slot,
    input  logic [12:0]                i_load_value,
    input  logic [9:0]                 i_source_vertex,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [10:0]                o_visited_total,
    output logic [9:0]                 o_vertex_id,
    output logic [10:0]                o_discovery_time,
    output logic [10:0]                o_finish_time,
    output logic signed [10:0]         o_parent_vertex,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [10:0]                i_cfg_data
);
    import dfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_ROOT, S_ROOTCHK, S_POP, S_ENT, S_CHK, S_ROW0,
        S_ROW1, S_EDGE, S_NB, S_NBCHK, S_DONE, S_RD1, S_RD2
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_vcount;
    logic            r_full;
    logic [SAW:0]    r_sp;
    logic [CW-1:0]   r_ts;
    logic [CW-1:0]   r_vc;
    logic [CW-1:0]   r_root;
    logic [VW-1:0]   r_v;
    logic [VW-1:0]   r_src;
    logic [VW-1:0]   r_clr;
    logic [VW-1:0]   r_nb;
    logic            r_nbok;
    logic [OW-1:0]   r_i;
    logic [OW-1:0]   r_lo;

    logic [CW-1:0]   w_n;
    logic            w_out_free;
    logic            w_accept;

    // RAM ports
    logic            row_we,  edge_we,  mark_we,  par_we,  disc_we,  fin_we,  list_we,  stk_we;
    logic [VW:0]     row_wa,  row_ra;
    logic [OW-1:0]   row_q;
    logic [EAW-1:0]  edge_wa, edge_ra;
    logic [VW:0]     edge_q;
    logic [VW-1:0]   mark_wa, mark_ra, par_wa, disc_wa, fin_wa, rec_ra, list_wa, list_ra;
    logic [1:0]      mark_wd, mark_q;
    logic [CW-1:0]   par_wd, par_q, disc_q, fin_wd, fin_q;
    logic [VW-1:0]   list_q;
    logic [SAW-1:0]  stk_wa, stk_ra;
    logic [VW:0]     stk_wd, stk_q;

    assign w_n        = (r_vcount > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : r_vcount;
    assign w_out_free = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    dfs_ram #(.DEPTH(MAX_VERTICES + 1), .WIDTH(OW)) u_row (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_wa), .i_wdata(i_load_value),
        .i_raddr(row_ra), .o_rdata(row_q));
    dfs_ram #(.DEPTH(MAX_EDGES), .WIDTH(VW + 1)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_wa),
        .i_wdata({|i_load_value[12:VW], i_load_value[VW-1:0]}),
        .i_raddr(edge_ra), .o_rdata(edge_q));
    dfs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(2)) u_mark (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(mark_wa), .i_wdata(mark_wd),
        .i_raddr(mark_ra), .o_rdata(mark_q));
    dfs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CW)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_wa), .i_wdata(par_wd),
        .i_raddr(rec_ra), .o_rdata(par_q));
    dfs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CW)) u_disc (
        .i_clk(i_clk), .i_we(disc_we), .i_waddr(disc_wa), .i_wdata(r_ts),
        .i_raddr(rec_ra), .o_rdata(disc_q));
    dfs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CW)) u_fin (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_wa), .i_wdata(fin_wd),
        .i_raddr(rec_ra), .o_rdata(fin_q));
    dfs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_wa), .i_wdata(r_v),
        .i_raddr(list_ra), .o_rdata(list_q));
    dfs_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VW + 1)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_q));

    always_comb begin
        row_we  = w_accept && (i_operation == OP_LOAD_ROW) && (i_slot <= 13'(MAX_VERTICES));
        row_wa  = i_slot[VW:0];
        row_ra  = (r_state == S_ROW0) ? ({1'b0, r_v} + (VW+1)'(1)) : {1'b0, r_v};
        edge_we = w_accept && (i_operation == OP_LOAD_EDGE) && (i_slot < 13'(MAX_EDGES));
        edge_wa = i_slot[EAW-1:0];
        edge_ra = EAW'(r_i - OW'(1));

        mark_we = 1'b0;
        mark_wa = r_v;
        mark_wd = MARK_NEW;
        par_we  = 1'b0;
        par_wa  = r_v;
        par_wd  = '1;
        disc_we = 1'b0;
        disc_wa = r_v;
        fin_we  = 1'b0;
        fin_wa  = r_v;
        fin_wd  = '0;
        list_we = 1'b0;
        list_wa = r_vc[VW-1:0];
        stk_we  = 1'b0;
        stk_wa  = r_sp[SAW-1:0];
        stk_wd  = {r_v, 1'b0};

        case (r_state)
            S_CLR: begin
                mark_we = 1'b1;
                mark_wa = r_clr;
                par_we  = 1'b1;
                par_wa  = r_clr;
                if (r_clr == VW'(MAX_VERTICES - 1) && !r_full) begin
                    stk_we = 1'b1;
                    stk_wa = '0;
                    stk_wd = {r_src, 1'b0};
                end
            end
            S_ROOTCHK: begin
                stk_we = (mark_q == MARK_NEW);
                stk_wd = {r_root[VW-1:0], 1'b0};
            end
            S_ENT: begin
                if (stk_q[0]) begin
                    mark_we = 1'b1;
                    mark_wa = stk_q[VW:1];
                    mark_wd = MARK_DONE;
                    fin_we  = 1'b1;
                    fin_wa  = stk_q[VW:1];
                    fin_wd  = r_ts;
                end
            end
            S_CHK: begin
                if (mark_q == MARK_NEW) begin
                    mark_we = 1'b1;
                    mark_wd = MARK_OPEN;
                    disc_we = 1'b1;
                    fin_we  = 1'b1;
                    list_we = 1'b1;
                    stk_we  = !r_sp[SAW];
                    stk_wd  = {r_v, 1'b1};
                end
            end
            S_NBCHK: begin
                if (r_nbok && mark_q == MARK_NEW) begin
                    par_we = 1'b1;
                    par_wa = r_nb;
                    par_wd = {1'b0, r_v};
                    stk_we = !r_sp[SAW];
                    stk_wd = {r_nb, 1'b0};
                end
            end
            default: ;
        endcase

        case (r_state)
            S_ROOT:  mark_ra = r_root[VW-1:0];
            S_ENT:   mark_ra = stk_q[VW:1];
            S_NB:    mark_ra = edge_q[VW-1:0];
            default: mark_ra = r_v;
        endcase
        rec_ra  = (r_state == S_RD1) ? list_q : r_v;
        list_ra = i_slot[VW-1:0];
        stk_ra  = SAW'(r_sp - (SAW+1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= CW'(1);
            r_full      <= 1'b0;
            r_sp        <= '0;
            r_ts        <= '0;
            r_vc        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_VERTEX_COUNT) begin
                    r_vcount <= i_cfg_data;
                end else begin
                    r_full <= i_cfg_data[0];
                end
            end
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        o_status         <= ST_OK;
                        o_visited_total  <= r_vc;
                        o_vertex_id      <= '0;
                        o_discovery_time <= '0;
                        o_finish_time    <= '0;
                        o_parent_vertex  <= '0;
                        r_src            <= i_source_vertex;
                        r_clr            <= '0;
                        case (i_operation)
                            OP_RUN: begin
                                if (!r_full && {1'b0, i_source_vertex} >= w_n) begin
                                    o_status    <= ST_BAD_SRC;
                                    o_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_CLR;
                                end
                            end
                            OP_READ: begin
                                if (i_slot < 13'(r_vc)) begin
                                    r_state <= S_RD1;
                                end else begin
                                    o_status    <= ST_BAD_RANK;
                                    o_out_valid <= 1'b1;
                                end
                            end
                            default: o_out_valid <= 1'b1;
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + VW'(1);
                    if (r_clr == VW'(MAX_VERTICES - 1)) begin
                        r_ts   <= '0;
                        r_vc   <= '0;
                        r_root <= '0;
                        if (r_full) begin
                            r_sp    <= '0;
                            r_state <= S_ROOT;
                        end else begin
                            r_sp    <= (SAW+1)'(1);
                            r_state <= S_POP;
                        end
                    end
                end
                S_ROOT: begin
                    r_state <= (r_root >= w_n) ? S_DONE : S_ROOTCHK;
                end
                S_ROOTCHK: begin
                    if (mark_q == MARK_NEW) begin
                        r_sp    <= (SAW+1)'(1);
                        r_state <= S_POP;
                    end else begin
                        r_root  <= r_root + CW'(1);
                        r_state <= S_ROOT;
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_root  <= r_root + CW'(1);
                        r_state <= r_full ? S_ROOT : S_DONE;
                    end else begin
                        r_sp    <= r_sp - (SAW+1)'(1);
                        r_state <= S_ENT;
                    end
                end
                S_ENT: begin
                    r_v <= stk_q[VW:1];
                    if (stk_q[0]) begin
                        r_ts    <= r_ts + CW'(1);
                        r_state <= S_POP;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (mark_q == MARK_NEW) begin
                        r_ts <= r_ts + CW'(1);
                        r_vc <= r_vc + CW'(1);
                        if (!r_sp[SAW]) begin
                            r_sp <= r_sp + (SAW+1)'(1);
                        end
                        r_state <= S_ROW0;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_ROW0: begin
                    r_lo    <= row_q;
                    r_state <= S_ROW1;
                end
                S_ROW1: begin
                    r_i     <= (row_q > OW'(MAX_EDGES)) ? OW'(MAX_EDGES) : row_q;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    if (r_i <= r_lo) begin
                        r_state <= S_POP;
                    end else begin
                        r_i     <= r_i - OW'(1);
                        r_state <= S_NB;
                    end
                end
                S_NB: begin
                    // targets at or above n are skipped
                    r_nb    <= edge_q[VW-1:0];
                    r_nbok  <= !edge_q[VW] && ({1'b0, edge_q[VW-1:0]} < w_n);
                    r_state <= S_NBCHK;
                end
                S_NBCHK: begin
                    if (r_nbok && mark_q == MARK_NEW && !r_sp[SAW]) begin
                        r_sp <= r_sp + (SAW+1)'(1);
                    end
                    r_state <= S_EDGE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_status        <= ST_OK;
                        o_visited_total <= r_vc;
                        o_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_RD1: begin
                    r_v     <= list_q;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    if (w_out_free) begin
                        o_vertex_id      <= r_v;
                        o_discovery_time <= disc_q;
                        o_finish_time    <= fin_q;
                        o_parent_vertex  <= par_q;
                        o_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/dfs_chk.sv @@
// ---------------------------------------------------------------------------
// dfs_chk
// Port-level checks of the DFS block, bound to the top level.
// ---------------------------------------------------------------------------
`include "dfs_discovery_finish_times_assert.svh"

module dfs_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [1:0]          o_status,
    input logic [10:0]         o_visited_total,
    input logic [9:0]          o_vertex_id,
    input logic [10:0]         o_discovery_time,
    input logic [10:0]         o_finish_time,
    input logic signed [10:0]  o_parent_vertex
);
    import dfs_pkg::*;

    `DFS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `DFS_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, o_status == ST_OK || o_status == ST_BAD_SRC || o_status == ST_BAD_RANK)
    `DFS_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_vertex_id == '0 && o_discovery_time == '0 && o_finish_time == '0 && o_parent_vertex == '0)
    `DFS_ASSERT_IMP(a_visit_range, i_clk, i_rst_n, o_out_valid, o_visited_total <= 11'(MAX_VERTICES))
endmodule

bind dfs_discovery_finish_times dfs_chk u_dfs_chk (.*);
